// ----- rtl/nsfc_pkg.sv -----
`default_nettype none

package nsfc_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	// shortest line that can pass, and shortest that carries a full tag
	localparam int MIN_LINE_CHARS = 10;
	localparam int MIN_TAG_CHARS  = 7;
	localparam int TAG_CHARS      = 6;

	localparam logic [47:0] TAG_PFLAU = 48'h50464C41552C; // "PFLAU,"
	localparam logic [47:0] TAG_PFLAA = 48'h50464C41412C; // "PFLAA,"
	localparam logic [47:0] TAG_GPRMC = 48'h4750524D432C; // "GPRMC,"
	localparam logic [47:0] TAG_GNRMC = 48'h474E524D432C; // "GNRMC,"
	localparam logic [47:0] TAG_GPGGA = 48'h47504747412C; // "GPGGA,"
	localparam logic [47:0] TAG_GNGGA = 48'h474E4747412C; // "GNGGA,"
	localparam logic [47:0] TAG_PGRMZ = 48'h5047524D5A2C; // "PGRMZ,"

	localparam logic [2:0] KIND_OTHER = 3'd0;
	localparam logic [2:0] KIND_PFLAU = 3'd1;
	localparam logic [2:0] KIND_PFLAA = 3'd2;
	localparam logic [2:0] KIND_RMC   = 3'd3;
	localparam logic [2:0] KIND_GGA   = 3'd4;
	localparam logic [2:0] KIND_PGRMZ = 3'd5;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_SHORT     = 3'd1;
	localparam logic [2:0] STATUS_NO_DOLLAR = 3'd2;
	localparam logic [2:0] STATUS_NO_STAR   = 3'd3;
	localparam logic [2:0] STATUS_BAD_SUM   = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] status;
		logic [7:0] computed;
		logic [7:0] received;
		logic [6:0] length;
	} nsfc_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} nsfc_hex_t;

	function automatic nsfc_hex_t hex_decode(input logic [7:0] b);
		nsfc_hex_t h;
		h.ok = 1'b1;
		h.nibble = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			h.nibble = 4'(b - 8'h30);
		end else if (b inside {[8'h41:8'h46]}) begin
			h.nibble = 4'(b - 8'h37);
		end else if (b inside {[8'h61:8'h66]}) begin
			h.nibble = 4'(b - 8'h57);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/nmea_sentence_framer_checker.sv -----
`default_nettype none

// Channel   Valid          Stall          Word
// rx        rx_valid       rx_stall       rx_byte
// result    result_valid   result_stall   sentence_kind, line_status, computed_sum,
//                                         received_sum, line_length
//
// One byte per cycle sustained unless a stalled result holds the flow: input
// register, one pass through the line state update, then the result register.
// result_valid presents a result once its CR/LF byte has left the input
// register. Reset clears the line state and both valid flags. A stalled
// result holds the input register; rx_stall rises only when the input
// register is full and the result register is full and stalled.

module nmea_sentence_framer_checker
	import nsfc_pkg::*;
#(
	parameter int LINE_BYTES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic      [2:0] sentence_kind,
	output logic      [2:0] line_status,
	output logic      [7:0] computed_sum,
	output logic      [7:0] received_sum,
	output logic      [6:0] line_length
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	logic         res_valid;
	nsfc_result_t res;
	logic         out_valid_q;
	nsfc_result_t out_q;

	assign advance  = !out_valid_q || !result_stall;
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	nsfc_line_state #(
		.LINE_BYTES(LINE_BYTES)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.data     (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid  = out_valid_q;
	assign sentence_kind = out_q.kind;
	assign line_status   = out_q.status;
	assign computed_sum  = out_q.computed;
	assign received_sum  = out_q.received;
	assign line_length   = out_q.length;

endmodule

`default_nettype wire

// ----- rtl/nsfc_tag_match.sv -----
`default_nettype none

module nsfc_tag_match
	import nsfc_pkg::*;
(
	input  wire logic [47:0] tag,
	input  wire logic        long_enough,
	output logic      [2:0]  kind
);

	always_comb begin
		kind = KIND_OTHER;
		if (long_enough) begin
			if (tag == TAG_PFLAU) begin
				kind = KIND_PFLAU;
			end else if (tag == TAG_PFLAA) begin
				kind = KIND_PFLAA;
			end else if (tag == TAG_GPRMC || tag == TAG_GNRMC) begin
				kind = KIND_RMC;
			end else if (tag == TAG_GPGGA || tag == TAG_GNGGA) begin
				kind = KIND_GGA;
			end else if (tag == TAG_PGRMZ) begin
				kind = KIND_PGRMZ;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nsfc_line_state.sv -----
`default_nettype none

module nsfc_line_state
	import nsfc_pkg::*;
#(
	parameter int LINE_BYTES = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   data,
	output logic              res_valid,
	output nsfc_result_t      res
);

	localparam int CW = $clog2(LINE_BYTES);

	logic [CW-1:0] count_q, count_d;
	logic          dollar_q, dollar_d;
	logic          star_q, star_d;
	logic          early_q, early_d;
	logic [7:0]    xor_q, xor_d;
	logic [7:0]    hex_q, hex_d;
	logic          hex_open_q, hex_open_d;
	logic [47:0]   tag_q, tag_d;

	logic          is_dollar;
	logic          is_eol;
	logic          has_room;
	nsfc_hex_t     hx;
	logic [2:0]    kind;

	assign is_dollar = (data == CHAR_DOLLAR);
	assign is_eol    = (data == CHAR_CR) || (data == CHAR_LF);
	assign has_room  = (count_q < CW'(LINE_BYTES - 1));
	assign hx        = hex_decode(data);

	nsfc_tag_match u_tag (
		.tag        (tag_q),
		.long_enough(count_q >= CW'(MIN_TAG_CHARS)),
		.kind       (kind)
	);

	always_comb begin
		res.kind     = kind;
		res.computed = xor_q;
		res.received = star_q ? hex_q : 8'd0;
		res.length   = 7'(count_q);
		if (count_q < CW'(MIN_LINE_CHARS)) begin
			res.status = STATUS_SHORT;
		end else if (!dollar_q) begin
			res.status = STATUS_NO_DOLLAR;
		end else if (!star_q || early_q) begin
			res.status = STATUS_NO_STAR;
		end else if (xor_q != hex_q) begin
			res.status = STATUS_BAD_SUM;
		end else begin
			res.status = STATUS_OK;
		end
	end

	assign res_valid = step && is_eol && (count_q != '0);

	always_comb begin
		count_d    = count_q;
		dollar_d   = dollar_q;
		star_d     = star_q;
		early_d    = early_q;
		xor_d      = xor_q;
		hex_d      = hex_q;
		hex_open_d = hex_open_q;
		tag_d      = tag_q;
		if (is_dollar) begin
			// '$' opens a fresh line holding just itself
			count_d    = CW'(1);
			dollar_d   = 1'b1;
			star_d     = 1'b0;
			early_d    = 1'b0;
			xor_d      = 8'd0;
			hex_d      = 8'd0;
			hex_open_d = 1'b0;
			tag_d      = '0;
		end else if (is_eol) begin
			count_d    = '0;
			dollar_d   = 1'b0;
			star_d     = 1'b0;
			early_d    = 1'b0;
			xor_d      = 8'd0;
			hex_d      = 8'd0;
			hex_open_d = 1'b0;
			tag_d      = '0;
		end else if (has_room) begin
			if (count_q == '0) begin
				dollar_d = 1'b0;
			end
			for (int i = 1; i <= TAG_CHARS; i++) begin
				if (count_q == CW'(i)) begin
					tag_d[8*(TAG_CHARS-i) +: 8] = tag_q[8*(TAG_CHARS-i) +: 8] | data;
				end
			end
			if (!star_q) begin
				if (data == CHAR_STAR) begin
					star_d     = 1'b1;
					early_d    = (count_q < CW'(2));
					hex_open_d = 1'b1;
					hex_d      = 8'd0;
				end else if (count_q != '0) begin
					xor_d = xor_q ^ data;
				end
			end else if (hex_open_q) begin
				if (hx.ok) begin
					hex_d = {hex_q[3:0], hx.nibble};
				end else begin
					hex_open_d = 1'b0;
				end
			end
			count_d = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dollar_q   <= 1'b0;
			star_q     <= 1'b0;
			early_q    <= 1'b0;
			xor_q      <= 8'd0;
			hex_q      <= 8'd0;
			hex_open_q <= 1'b0;
			tag_q      <= '0;
		end else if (step) begin
			count_q    <= count_d;
			dollar_q   <= dollar_d;
			star_q     <= star_d;
			early_q    <= early_d;
			xor_q      <= xor_d;
			hex_q      <= hex_d;
			hex_open_q <= hex_open_d;
			tag_q      <= tag_d;
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import nsfc_pkg::*;

	localparam int LINE_BYTES   = 128;
	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_BYTES = 100;
	localparam int TAIL_CYCLES  = 16;

	typedef logic [7:0] octets_t[$];

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       rx_valid     = 1'b0;
	logic [7:0] rx_byte      = 8'h00;
	logic       result_stall = 1'b0;
	logic       rx_stall;
	logic       result_valid;
	logic [2:0] sentence_kind;
	logic [2:0] line_status;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [6:0] line_length;

	nmea_sentence_framer_checker #(
		.LINE_BYTES(LINE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sentence_kind(sentence_kind),
		.line_status(line_status),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.line_length(line_length)
	);

	always #5 clk = ~clk;

	// line state mirrored from the block
	int unsigned  ln_count;
	bit           ln_dollar;
	bit           ln_star;
	bit           ln_early;
	bit           ln_hex_open;
	logic [7:0]   ln_xor;
	logic [7:0]   ln_hex;
	logic [47:0]  ln_tag;

	nsfc_result_t pending_reports[$];
	int           errors     = 0;
	int           bytes_sent = 0;
	bit           send_calm  = 1'b0;
	bit           take_calm  = 1'b0;
	int           hold_left  = 0;
	bit           hold_drawn = 1'b0;

	string tag_pool[11] = '{"PFLAU,", "PFLAA,", "GPRMC,", "GNRMC,", "GPGGA,", "GNGGA,",
		"PGRMZ,", "GPRMX,", "PFLAU;", "GNGGB,", "PGRMZZ"};

	function automatic void line_clear();
		ln_count    = 0;
		ln_dollar   = 1'b0;
		ln_star     = 1'b0;
		ln_early    = 1'b0;
		ln_hex_open = 1'b0;
		ln_xor      = 8'h00;
		ln_hex      = 8'h00;
		ln_tag      = '0;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "A" && c <= "F") return int'(c) - 55;
		if (c >= "a" && c <= "f") return int'(c) - 87;
		return -1;
	endfunction

	function automatic void line_store(input logic [7:0] c);
		int d;
		if (ln_count == 0) ln_dollar = (c == CHAR_DOLLAR);
		if (ln_count >= 1 && ln_count <= TAG_CHARS) ln_tag[8 * (TAG_CHARS - ln_count) +: 8] = c;
		if (!ln_star) begin
			if (c == CHAR_STAR) begin
				ln_star     = 1'b1;
				ln_early    = (ln_count < 2);
				ln_hex_open = 1'b1;
				ln_hex      = 8'h00;
			end else if (ln_count >= 1) begin
				ln_xor ^= c;
			end
		end else if (ln_hex_open) begin
			d = hex_digit(c);
			if (d >= 0) ln_hex = {ln_hex[3:0], 4'(d)};
			else ln_hex_open = 1'b0;
		end
		ln_count++;
	endfunction

	function automatic logic [2:0] line_kind();
		if (ln_count < MIN_TAG_CHARS) return KIND_OTHER;
		case (ln_tag)
			TAG_PFLAU: return KIND_PFLAU;
			TAG_PFLAA: return KIND_PFLAA;
			TAG_GPRMC, TAG_GNRMC: return KIND_RMC;
			TAG_GPGGA, TAG_GNGGA: return KIND_GGA;
			TAG_PGRMZ: return KIND_PGRMZ;
			default: return KIND_OTHER;
		endcase
	endfunction

	// returns 1 when the byte closes a non-empty line
	function automatic bit line_take(input logic [7:0] c, output nsfc_result_t r);
		r = '0;
		if (c == CHAR_DOLLAR) begin
			line_clear();
			line_store(c);
			return 1'b0;
		end
		if (c == CHAR_CR || c == CHAR_LF) begin
			if (ln_count == 0) return 1'b0;
			r.kind = line_kind();
			if (ln_count < MIN_LINE_CHARS) r.status = STATUS_SHORT;
			else if (!ln_dollar) r.status = STATUS_NO_DOLLAR;
			else if (!ln_star || ln_early) r.status = STATUS_NO_STAR;
			else if (ln_xor != ln_hex) r.status = STATUS_BAD_SUM;
			else r.status = STATUS_OK;
			r.computed = ln_xor;
			r.received = ln_star ? ln_hex : 8'h00;
			r.length   = 7'(ln_count);
			line_clear();
			return 1'b1;
		end
		if (ln_count < LINE_BYTES - 1) line_store(c);
		return 1'b0;
	endfunction

	function automatic octets_t text(input string s);
		octets_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 10) return 8'(8'h30 + n);
		return 8'((lower ? 8'h61 : 8'h41) + n - 10);
	endfunction

	// '$' body '*' checksum CR LF; extra leading digits get shifted out by the block
	function automatic octets_t sentence(input octets_t body, input int digits, input bit good,
			input bit lower);
		octets_t    q;
		logic [7:0] x;
		logic [7:0] s;
		x = 8'h00;
		q.push_back(CHAR_DOLLAR);
		foreach (body[i]) begin
			q.push_back(body[i]);
			x ^= body[i];
		end
		q.push_back(CHAR_STAR);
		s = good ? x : x ^ 8'($urandom_range(1, 255));
		for (int k = digits - 1; k >= 0; k--)
			q.push_back(hex_char(k < 2 ? s[4 * k +: 4] : 4'($urandom_range(0, 15)), lower));
		q.push_back(CHAR_CR);
		q.push_back(CHAR_LF);
		return q;
	endfunction

	function automatic octets_t random_body(input int len);
		octets_t    q;
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			c = 8'($urandom_range(8'h20, 8'h7E));
			if (c == CHAR_DOLLAR || c == CHAR_STAR) c = ",";
			q.push_back(c);
		end
		return q;
	endfunction

	task automatic send_byte(input logic [7:0] c);
		int           gap;
		nsfc_result_t r;
		gap = send_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= c;
		do @(posedge clk); while (rx_stall);
		if (line_take(c, r)) pending_reports.push_back(r);
		bytes_sent++;
	endtask

	task automatic send_line(input octets_t q);
		foreach (q[i]) send_byte(q[i]);
	endtask

	// sender holds off until every report has come back
	task automatic drain_results();
		rx_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		nsfc_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected word, expected none, got kind %0d status %0d length %0d",
					$time, sentence_kind, line_status, line_length);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("sentence_kind", 8'(want.kind), 8'(sentence_kind));
				check_field("line_status", 8'(want.status), 8'(line_status));
				check_field("computed_sum", want.computed, computed_sum);
				check_field("received_sum", want.received, received_sum);
				check_field("line_length", 8'(want.length), 8'(line_length));
			end
		end
	end

	// receiver stall: a fresh hold count after every word taken
	always @(posedge clk) begin
		if (result_valid && !result_stall) hold_drawn = 1'b0;
		if (!hold_drawn) begin
			hold_left  = take_calm ? 0 : $urandom_range(0, 8);
			hold_drawn = 1'b1;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rx_valid && !rx_stall) || (result_valid && !result_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("%0t: timeout, %0d words still expected", $time, pending_reports.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic test_sentence_kinds();
		for (int i = 0; i < 7; i++)
			send_line(sentence(text({tag_pool[i], "1,2"}), 2, 1'b1, i[0]));
	endtask

	task automatic test_status_codes();
		octets_t q;
		// too short, followed by LF on an empty line
		send_line(sentence(text("A"), 2, 1'b1, 1'b0));
		q = sentence(text("GPGGA,12"), 2, 1'b1, 1'b0);
		void'(q.pop_front());
		send_line(q);
		q = text("$GPRMC,123456");
		q.push_back(CHAR_CR);
		send_line(q);
		// asterisk right after the dollar
		q = text("$*0123456789");
		q.push_back(CHAR_LF);
		send_line(q);
		send_line(sentence(text("PFLAA,0,1"), 2, 1'b0, 1'b1));
	endtask

	task automatic test_checksum_digits();
		send_line(sentence(text("PGRMZ,93"), 0, 1'b1, 1'b0));
		send_line(sentence(text("PGRMZ,94"), 1, 1'b1, 1'b0));
		send_line(sentence(text("GNRMC,5"), 4, 1'b1, 1'b1));
	endtask

	task automatic test_odd_bytes();
		octets_t q;
		q = text("GNGGA,");
		q.push_back(8'h00);
		q.push_back(8'hFF);
		q.push_back(8'h80);
		send_line(sentence(q, 2, 1'b1, 1'b0));
		// a dollar in mid line starts over
		send_line(text("$GPXYZ,12"));
		send_line(sentence(text("PFLAU,3"), 2, 1'b1, 1'b0));
		q = text("$");
		q.push_back(CHAR_CR);
		q.push_back(CHAR_LF);
		q.push_back(CHAR_CR);
		send_line(q);
	endtask

	task automatic test_full_store();
		send_calm = 1'b1;
		send_line(sentence(random_body(120), 2, 1'b1, 1'b0));
		send_line(sentence(random_body(126), 2, 1'b1, 1'b0));
		send_line(sentence(random_body(140), 2, 1'b1, 1'b1));
		send_calm = 1'b0;
	endtask

	task automatic test_result_drain();
		send_line(sentence(text("GPGGA,1,2,3"), 2, 1'b1, 1'b0));
		drain_results();
		send_line(sentence(text("GPRMC,4,5,6"), 2, 1'b1, 1'b0));
	endtask

	task automatic test_back_to_back();
		send_calm = 1'b1;
		for (int i = 0; i < 3; i++) send_line(sentence(random_body(4), 2, 1'b1, 1'b0));
		take_calm = 1'b1;
		for (int i = 0; i < 3; i++) send_line(sentence(random_body(4), 2, 1'b1, 1'b1));
		send_calm = 1'b0;
		take_calm = 1'b0;
	endtask

	task automatic test_random_stream();
		int      stop_at;
		int      pick;
		int      len;
		octets_t q;
		octets_t body;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) send_calm = !send_calm;
			if ($urandom_range(0, 9) == 0) take_calm = !take_calm;
			if ($urandom_range(0, 29) == 0) drain_results();
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				len = $urandom_range(1, 8);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end else begin
				body = ($urandom_range(0, 9) < 7) ?
					text(tag_pool[$urandom_range(0, 10)]) : random_body(6);
				len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 130) :
					$urandom_range(0, 12);
				body = {body, random_body(len)};
				q = sentence(body, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 2,
					$urandom_range(0, 6) != 0, $urandom_range(0, 1));
				if ($urandom_range(0, 2) == 0) void'(q.pop_back());
				if (pick == 1) begin
					case ($urandom_range(0, 2))
						0: void'(q.pop_front());
						1: begin
							void'(q.pop_back());
							void'(q.pop_back());
						end
						default: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
					endcase
				end
				send_line(q);
			end
		end
		send_calm = 1'b0;
		take_calm = 1'b0;
	endtask

	initial begin
		line_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_sentence_kinds();
		test_status_codes();
		test_checksum_digits();
		test_odd_bytes();
		test_full_store();
		test_result_drain();
		test_back_to_back();
		test_random_stream();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/nsfc_pkg.sv
rtl/nsfc_tag_match.sv
rtl/nsfc_line_state.sv
rtl/nmea_sentence_framer_checker.sv
tb/sv/testbench.sv
